[src/stog_pkg.sv]
// ----------------------------------------------------------------------------
// stog_pkg
// Shared types and codes for the spiral tile order generator.
// ----------------------------------------------------------------------------
package stog_pkg;

  // operation codes of a request item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // edge phases of the ring walk
  localparam logic [1:0] PH_TOP    = 2'd0;
  localparam logic [1:0] PH_BOTTOM = 2'd1;
  localparam logic [1:0] PH_LEFT   = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  // fixed field widths
  localparam int POS_W  = 16;
  localparam int SIZE_W = 8;

  // request item
  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] rect_left;
    logic [POS_W-1:0] rect_top;
    logic [POS_W-1:0] rect_width;
    logic [POS_W-1:0] rect_height;
  } req_t;

  // result item
  typedef struct packed {
    logic              tile_valid;
    logic [POS_W-1:0]  tile_left;
    logic [POS_W-1:0]  tile_top;
    logic [SIZE_W-1:0] tile_width;
    logic [SIZE_W-1:0] tile_height;
    logic              tile_last;
  } rsp_t;

endpackage

[src/stog_snap.sv]
// ----------------------------------------------------------------------------
// stog_snap
// Clamps a loaded rectangle and snaps its bounds outward to the tile grid.
// ----------------------------------------------------------------------------
module stog_snap #(
  parameter int TILE_EDGE  = 128,
  parameter int COORD_BITS = 16,
  parameter int CW         = 17
) (
  input  logic [stog_pkg::POS_W-1:0] rect_left,
  input  logic [stog_pkg::POS_W-1:0] rect_top,
  input  logic [stog_pkg::POS_W-1:0] rect_width,
  input  logic [stog_pkg::POS_W-1:0] rect_height,
  output logic [CW-1:0]              clip_left,
  output logic [CW-1:0]              clip_top,
  output logic [CW-1:0]              clip_right,
  output logic [CW-1:0]              clip_bottom,
  output logic [CW-1:0]              snap_left,
  output logic [CW-1:0]              snap_top,
  output logic [CW-1:0]              snap_right,
  output logic [CW-1:0]              snap_bottom,
  output logic                       nonempty
);

  localparam logic [CW-1:0] COORD_MAX = CW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [CW-1:0] MASK      = CW'(TILE_EDGE - 1);

  logic [CW-1:0] left_ext;
  logic [CW-1:0] top_ext;
  logic [CW-1:0] right_sum;
  logic [CW-1:0] bottom_sum;
  logic [CW-1:0] right_up;
  logic [CW-1:0] bottom_up;

  // clamp edges to the coordinate range
  always_comb begin
    left_ext    = CW'(rect_left);
    top_ext     = CW'(rect_top);
    clip_left   = (left_ext > COORD_MAX) ? COORD_MAX : left_ext;
    clip_top    = (top_ext > COORD_MAX) ? COORD_MAX : top_ext;
    right_sum   = clip_left + CW'(rect_width);
    bottom_sum  = clip_top + CW'(rect_height);
    clip_right  = (right_sum > COORD_MAX) ? COORD_MAX : right_sum;
    clip_bottom = (bottom_sum > COORD_MAX) ? COORD_MAX : bottom_sum;
  end

  // snap outward to the tile grid
  always_comb begin
    right_up    = clip_right + MASK;
    bottom_up   = clip_bottom + MASK;
    snap_left   = clip_left & ~MASK;
    snap_top    = clip_top & ~MASK;
    snap_right  = right_up & ~MASK;
    snap_bottom = bottom_up & ~MASK;
    nonempty    = (clip_right > clip_left) && (clip_bottom > clip_top);
  end

endmodule

[src/stog_walk.sv]
// ----------------------------------------------------------------------------
// stog_walk
// Ring walk state and the per-request tile step with clipping.
// ----------------------------------------------------------------------------
module stog_walk #(
  parameter int TILE_EDGE = 128,
  parameter int CW        = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           next,
  input  logic [CW-1:0]  ld_clip_left,
  input  logic [CW-1:0]  ld_clip_top,
  input  logic [CW-1:0]  ld_clip_right,
  input  logic [CW-1:0]  ld_clip_bottom,
  input  logic [CW-1:0]  ld_snap_left,
  input  logic [CW-1:0]  ld_snap_top,
  input  logic [CW-1:0]  ld_snap_right,
  input  logic [CW-1:0]  ld_snap_bottom,
  input  logic           ld_nonempty,
  output stog_pkg::rsp_t result
);

  localparam logic [CW-1:0] TILE = CW'(TILE_EDGE);

  // rectangle and ring state
  logic [CW-1:0] rect_left;
  logic [CW-1:0] rect_top;
  logic [CW-1:0] rect_right;
  logic [CW-1:0] rect_bottom;
  logic [CW-1:0] ring_left;
  logic [CW-1:0] ring_top;
  logic [CW-1:0] ring_right;
  logic [CW-1:0] ring_bottom;
  logic [1:0]    edge_phase;
  logic [CW-1:0] edge_cursor;
  logic          walk_active;

  logic [CW-1:0] ring_left_next;
  logic [CW-1:0] ring_top_next;
  logic [CW-1:0] ring_right_next;
  logic [CW-1:0] ring_bottom_next;
  logic [1:0]    edge_phase_next;
  logic [CW-1:0] edge_cursor_next;
  logic          walk_active_next;

  logic [CW-1:0] tx;
  logic [CW-1:0] ty;
  logic [CW-1:0] cl;
  logic [CW-1:0] ct;
  logic [CW-1:0] cr;
  logic [CW-1:0] cb;
  logic [CW-1:0] tile_r;
  logic [CW-1:0] tile_b;
  logic [CW-1:0] cursor_inc;
  logic          edge_done;
  logic          last;

  // tile position for the current edge
  always_comb begin
    unique case (edge_phase)
      stog_pkg::PH_TOP: begin
        tx = edge_cursor;
        ty = ring_top;
      end
      stog_pkg::PH_BOTTOM: begin
        tx = edge_cursor;
        ty = ring_bottom - TILE;
      end
      stog_pkg::PH_LEFT: begin
        tx = ring_left;
        ty = edge_cursor;
      end
      default: begin
        tx = ring_right - TILE;
        ty = edge_cursor;
      end
    endcase
  end

  // clip the tile to the rectangle
  always_comb begin
    tile_r = tx + TILE;
    tile_b = ty + TILE;
    cl     = (tx > rect_left) ? tx : rect_left;
    ct     = (ty > rect_top) ? ty : rect_top;
    cr     = (tile_r < rect_right) ? tile_r : rect_right;
    cb     = (tile_b < rect_bottom) ? tile_b : rect_bottom;
    if (cr < cl) begin
      cr = cl;
    end
    if (cb < ct) begin
      cb = ct;
    end
  end

  // advance the cursor, shrink the ring at the end of an edge
  always_comb begin
    cursor_inc       = edge_cursor + TILE;
    edge_done        = (edge_phase[1] == 1'b0) ? (cursor_inc >= ring_right)
                                               : (cursor_inc >= ring_bottom);
    ring_left_next   = ring_left;
    ring_top_next    = ring_top;
    ring_right_next  = ring_right;
    ring_bottom_next = ring_bottom;
    edge_phase_next  = edge_phase;
    edge_cursor_next = cursor_inc;
    walk_active_next = walk_active;
    last             = 1'b0;
    if (edge_done) begin
      unique case (edge_phase)
        stog_pkg::PH_TOP:    ring_top_next    = ring_top + TILE;
        stog_pkg::PH_BOTTOM: ring_bottom_next = ring_bottom - TILE;
        stog_pkg::PH_LEFT:   ring_left_next   = ring_left + TILE;
        default:             ring_right_next  = ring_right - TILE;
      endcase
      if ((ring_right_next <= ring_left_next) || (ring_bottom_next <= ring_top_next)) begin
        walk_active_next = 1'b0;
        last             = 1'b1;
      end else begin
        edge_phase_next  = edge_phase + 2'd1;
        edge_cursor_next = (edge_phase_next[1] == 1'b0) ? ring_left_next : ring_top_next;
      end
    end
  end

  // result for a request
  always_comb begin
    result = '0;
    if (walk_active) begin
      result.tile_valid  = 1'b1;
      result.tile_left   = cl[stog_pkg::POS_W-1:0];
      result.tile_top    = ct[stog_pkg::POS_W-1:0];
      result.tile_width  = stog_pkg::SIZE_W'(cr - cl);
      result.tile_height = stog_pkg::SIZE_W'(cb - ct);
      result.tile_last   = last;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= '0;
      rect_bottom <= '0;
      ring_left   <= '0;
      ring_top    <= '0;
      ring_right  <= '0;
      ring_bottom <= '0;
      edge_phase  <= stog_pkg::PH_TOP;
      edge_cursor <= '0;
      walk_active <= 1'b0;
    end else if (load) begin
      rect_left   <= ld_clip_left;
      rect_top    <= ld_clip_top;
      rect_right  <= ld_clip_right;
      rect_bottom <= ld_clip_bottom;
      ring_left   <= ld_snap_left;
      ring_top    <= ld_snap_top;
      ring_right  <= ld_snap_right;
      ring_bottom <= ld_snap_bottom;
      edge_phase  <= stog_pkg::PH_TOP;
      edge_cursor <= ld_snap_left;
      walk_active <= ld_nonempty;
    end else if (next && walk_active) begin
      ring_left   <= ring_left_next;
      ring_top    <= ring_top_next;
      ring_right  <= ring_right_next;
      ring_bottom <= ring_bottom_next;
      edge_phase  <= edge_phase_next;
      edge_cursor <= edge_cursor_next;
      walk_active <= walk_active_next;
    end
  end

endmodule

[src/spiral_tile_order_generator_core.sv]
// A next item passes the input register and then the result register.
// Throughput: one item per cycle unless a next item waits on rsp_stall.
// A load item gives no result and never waits on the result side.
// TILE_EDGE must be a power of two (grid snapping is a mask).
// Reset (rst, synchronous) empties both registers and leaves the walk idle.
// ----------------------------------------------------------------------------
// spiral_tile_order_generator_core
// Lists the clipped tiles of a rectangle in a spiral from the outside in.
// ----------------------------------------------------------------------------
module spiral_tile_order_generator_core #(
  parameter int TILE_EDGE  = 128,
  parameter int COORD_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  stog_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output stog_pkg::rsp_t rsp
);

  localparam int TSHIFT = $clog2(TILE_EDGE);
  localparam int CW0    = (COORD_BITS > TSHIFT) ? COORD_BITS : TSHIFT;
  localparam int CW     = ((CW0 > stog_pkg::POS_W) ? CW0 : stog_pkg::POS_W) + 1;

  logic           in_full;
  stog_pkg::req_t in_item;
  logic           fire;
  logic           is_next;
  logic           out_full;
  stog_pkg::rsp_t step_rsp;

  logic [CW-1:0] clip_left;
  logic [CW-1:0] clip_top;
  logic [CW-1:0] clip_right;
  logic [CW-1:0] clip_bottom;
  logic [CW-1:0] snap_left;
  logic [CW-1:0] snap_top;
  logic [CW-1:0] snap_right;
  logic [CW-1:0] snap_bottom;
  logic          nonempty;

  // the held item proceeds when it is a load or the result slot frees up
  assign is_next   = (in_item.operation == stog_pkg::OP_NEXT);
  assign fire      = in_full && (!is_next || !out_full || !rsp_stall);
  assign req_stall = in_full && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_item <= req;
    end
  end

  stog_snap #(
    .TILE_EDGE  (TILE_EDGE),
    .COORD_BITS (COORD_BITS),
    .CW         (CW)
  ) u_snap (
    .rect_left   (in_item.rect_left),
    .rect_top    (in_item.rect_top),
    .rect_width  (in_item.rect_width),
    .rect_height (in_item.rect_height),
    .clip_left   (clip_left),
    .clip_top    (clip_top),
    .clip_right  (clip_right),
    .clip_bottom (clip_bottom),
    .snap_left   (snap_left),
    .snap_top    (snap_top),
    .snap_right  (snap_right),
    .snap_bottom (snap_bottom),
    .nonempty    (nonempty)
  );

  stog_walk #(
    .TILE_EDGE (TILE_EDGE),
    .CW        (CW)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .load           (fire && !is_next),
    .next           (fire && is_next),
    .ld_clip_left   (clip_left),
    .ld_clip_top    (clip_top),
    .ld_clip_right  (clip_right),
    .ld_clip_bottom (clip_bottom),
    .ld_snap_left   (snap_left),
    .ld_snap_top    (snap_top),
    .ld_snap_right  (snap_right),
    .ld_snap_bottom (snap_bottom),
    .ld_nonempty    (nonempty),
    .result         (step_rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire && is_next) begin
      out_full <= 1'b1;
    end else if (!rsp_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_next) begin
      rsp <= step_rsp;
    end
  end

  assign rsp_valid = out_full;

endmodule

[src/stog_checker.sv]
// ----------------------------------------------------------------------------
// stog_checker
// Port-level checks for the spiral tile order generator.
// ----------------------------------------------------------------------------
module stog_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input stog_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input stog_pkg::rsp_t rsp
);

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // an idle answer carries all-zero fields
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.tile_valid |-> rsp == '0)
    else $error("invalid tile with nonzero fields");

  // the last mark only comes with a real tile
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.tile_last |-> rsp.tile_valid)
    else $error("last mark on invalid tile");

  // a fresh result comes from an accepted next request
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      $past(req_valid && !req_stall && !rst && req.operation == stog_pkg::OP_NEXT, 2))
    else $error("result item without a matching request");

endmodule

bind spiral_tile_order_generator_core stog_checker u_stog_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
